@@ rtl/qslc_pkg.sv @@
// qslc_pkg: shared types, constants and helpers for the quicksort block
// used by every module under rtl; depends on nothing
`default_nettype none

package qslc_pkg;

    // element store geometry; range entries hold 6-bit low/high indexes
    localparam int STORE_DEPTH   = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int VALUE_W       = 64;
    localparam int STAT_W        = 12;
    localparam int RANGE_W       = 2 * IDX_W;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int M_TDATA_W     = VALUE_W + 2 * STAT_W;

    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_SCAN,
        ST_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_PLACE,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_PUSH_HI,
        ST_PUSH_LO,
        ST_OUT_RD,
        ST_OUT_LD
    } qs_state_t;

    // element memory access for one cycle
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } elem_req_t;

    // range stack access for one cycle; data is {hi, lo}
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [RANGE_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } stack_req_t;

    // saturating statistics counter step
    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] cnt);
        sat_inc = (cnt == STAT_MAX) ? cnt : cnt + STAT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/qslc_elem_ram.sv @@
// qslc_elem_ram: element store, one write and one registered read port
// depends on qslc_pkg for the request struct and geometry
`default_nettype none

module qslc_elem_ram (
    input  wire logic                          aclk,
    input  wire qslc_pkg::elem_req_t           req,
    output logic [qslc_pkg::VALUE_W-1:0]       rd_data
);

    logic [qslc_pkg::VALUE_W-1:0] mem [qslc_pkg::STORE_DEPTH];
    logic [qslc_pkg::VALUE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data valid the cycle after the request
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/qslc_stack_ram.sv @@
// qslc_stack_ram: stack of pending index ranges, one write and one read port
// depends on qslc_pkg for the request struct and geometry
`default_nettype none

module qslc_stack_ram (
    input  wire logic                          aclk,
    input  wire qslc_pkg::stack_req_t          req,
    output logic [qslc_pkg::RANGE_W-1:0]       rd_data
);

    logic [qslc_pkg::RANGE_W-1:0] mem [qslc_pkg::STORE_DEPTH];
    logic [qslc_pkg::RANGE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data valid the cycle after the request
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/qslc_ctrl.sv @@
// qslc_ctrl: load, partition sequencer, range stack control and output register
// depends on qslc_pkg; drives qslc_elem_ram and qslc_stack_ram
`default_nettype none

module qslc_ctrl #(
    parameter int MAX_ITEMS = qslc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [qslc_pkg::VALUE_W-1:0]     s_tdata,
    input  wire logic                             s_tlast,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [qslc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser,
    // memories
    output qslc_pkg::elem_req_t                   elem_req,
    input  wire logic [qslc_pkg::VALUE_W-1:0]     elem_rdata,
    output qslc_pkg::stack_req_t                  stack_req,
    input  wire logic [qslc_pkg::RANGE_W-1:0]     stack_rdata
);

    localparam int IDX_W  = qslc_pkg::IDX_W;
    localparam int CNT_W  = qslc_pkg::CNT_W;
    localparam int STAT_W = qslc_pkg::STAT_W;
    localparam logic [CNT_W-1:0] CAP       = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] STACK_CAP = CNT_W'(qslc_pkg::STORE_DEPTH);

    qslc_pkg::qs_state_t state_reg, state_next;

    logic [CNT_W-1:0]             item_cnt_reg, item_cnt_next;
    logic                         dropped_reg, dropped_next;
    logic [CNT_W-1:0]             sp_reg, sp_next;
    logic [STAT_W-1:0]            cmp_cnt_reg, cmp_cnt_next;
    logic [STAT_W-1:0]            xch_cnt_reg, xch_cnt_next;
    logic [IDX_W-1:0]             lo_reg, lo_next;
    logic [IDX_W-1:0]             hi_reg, hi_next;
    logic [IDX_W-1:0]             j_reg, j_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic [IDX_W-1:0]             out_k_reg, out_k_next;
    logic [qslc_pkg::VALUE_W-1:0] pivot_reg, pivot_next;
    logic [qslc_pkg::VALUE_W-1:0] hold_reg, hold_next;

    logic                         out_valid_reg, out_valid_next;
    logic [qslc_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                         out_last_reg, out_last_next;
    logic [STAT_W-1:0]            out_cmp_reg, out_cmp_next;
    logic [STAT_W-1:0]            out_xch_reg, out_xch_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic             s_fire;
    logic             le_pivot;
    logic             scan_done_next;
    logic             out_free;
    logic             out_is_last;
    logic [IDX_W-1:0] j_inc;
    logic [CNT_W-1:0] p_ext;

    assign s_fire         = s_tvalid && s_tready;
    assign le_pivot       = $signed(elem_rdata) <= $signed(pivot_reg);
    assign j_inc          = j_reg + IDX_W'(1);
    assign scan_done_next = (j_inc == hi_reg);
    assign out_free       = !out_valid_reg || m_tready;
    assign out_is_last    = ({1'b0, out_k_reg} + CNT_W'(1)) == item_cnt_reg;
    assign p_ext          = {1'b0, slot_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qslc_pkg::ST_LOAD: begin
                if (s_fire && s_tlast) begin
                    state_next = qslc_pkg::ST_START;
                end
            end
            qslc_pkg::ST_START:    state_next = qslc_pkg::ST_POP;
            qslc_pkg::ST_POP: begin
                state_next = (sp_reg == '0) ? qslc_pkg::ST_OUT_RD : qslc_pkg::ST_POP_WAIT;
            end
            qslc_pkg::ST_POP_WAIT: begin
                if (stack_rdata[IDX_W-1:0] >= stack_rdata[2*IDX_W-1:IDX_W]) begin
                    state_next = qslc_pkg::ST_POP;
                end else begin
                    state_next = qslc_pkg::ST_PIVOT;
                end
            end
            qslc_pkg::ST_PIVOT:    state_next = qslc_pkg::ST_SCAN;
            qslc_pkg::ST_SCAN:     state_next = qslc_pkg::ST_CMP;
            qslc_pkg::ST_CMP: begin
                if (le_pivot) begin
                    state_next = qslc_pkg::ST_SWAP_RD;
                end else if (scan_done_next) begin
                    state_next = qslc_pkg::ST_PLACE;
                end else begin
                    state_next = qslc_pkg::ST_SCAN;
                end
            end
            qslc_pkg::ST_SWAP_RD:  state_next = qslc_pkg::ST_SWAP_WR;
            qslc_pkg::ST_SWAP_WR: begin
                state_next = scan_done_next ? qslc_pkg::ST_PLACE : qslc_pkg::ST_SCAN;
            end
            qslc_pkg::ST_PLACE:    state_next = qslc_pkg::ST_PLACE_RD;
            qslc_pkg::ST_PLACE_RD: state_next = qslc_pkg::ST_PLACE_WR;
            qslc_pkg::ST_PLACE_WR: state_next = qslc_pkg::ST_PUSH_HI;
            qslc_pkg::ST_PUSH_HI:  state_next = qslc_pkg::ST_PUSH_LO;
            qslc_pkg::ST_PUSH_LO:  state_next = qslc_pkg::ST_POP;
            qslc_pkg::ST_OUT_RD: begin
                if (out_free) begin
                    state_next = qslc_pkg::ST_OUT_LD;
                end
            end
            qslc_pkg::ST_OUT_LD: begin
                state_next = out_is_last ? qslc_pkg::ST_LOAD : qslc_pkg::ST_OUT_RD;
            end
        endcase
    end

    // memory requests and datapath next values
    always_comb begin
        elem_req       = '0;
        stack_req      = '0;
        s_tready       = 1'b0;
        item_cnt_next  = item_cnt_reg;
        dropped_next   = dropped_reg;
        sp_next        = sp_reg;
        cmp_cnt_next   = cmp_cnt_reg;
        xch_cnt_next   = xch_cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        slot_next      = slot_reg;
        out_k_next     = out_k_reg;
        pivot_next     = pivot_reg;
        hold_next      = hold_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_cmp_next   = out_cmp_reg;
        out_xch_next   = out_xch_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            // store items until the marked one, drop past capacity
            qslc_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    if (item_cnt_reg < CAP) begin
                        elem_req.we    = 1'b1;
                        elem_req.waddr = item_cnt_reg[IDX_W-1:0];
                        elem_req.wdata = s_tdata;
                        item_cnt_next  = item_cnt_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            // whole store as the first range, pushed only if it holds at least two items
            qslc_pkg::ST_START: begin
                sp_next = '0;
                if (item_cnt_reg >= CNT_W'(2)) begin
                    stack_req.we    = 1'b1;
                    stack_req.waddr = '0;
                    stack_req.wdata = {IDX_W'(item_cnt_reg - CNT_W'(1)), IDX_W'(0)};
                    sp_next         = CNT_W'(1);
                end
            end
            qslc_pkg::ST_POP: begin
                out_k_next = '0;
                if (sp_reg != '0) begin
                    stack_req.re    = 1'b1;
                    stack_req.raddr = IDX_W'(sp_reg - CNT_W'(1));
                    sp_next         = sp_reg - CNT_W'(1);
                end
            end
            // unpack the range and fetch its pivot
            qslc_pkg::ST_POP_WAIT: begin
                lo_next        = stack_rdata[IDX_W-1:0];
                hi_next        = stack_rdata[2*IDX_W-1:IDX_W];
                elem_req.re    = 1'b1;
                elem_req.raddr = stack_rdata[2*IDX_W-1:IDX_W];
            end
            qslc_pkg::ST_PIVOT: begin
                pivot_next = elem_rdata;
                slot_next  = lo_reg;
                j_next     = lo_reg;
            end
            qslc_pkg::ST_SCAN: begin
                elem_req.re    = 1'b1;
                elem_req.raddr = j_reg;
            end
            // compare against the pivot; on a hit fetch the slot element
            qslc_pkg::ST_CMP: begin
                cmp_cnt_next = qslc_pkg::sat_inc(cmp_cnt_reg);
                if (le_pivot) begin
                    hold_next      = elem_rdata;
                    elem_req.re    = 1'b1;
                    elem_req.raddr = slot_reg;
                end else begin
                    j_next = j_inc;
                end
            end
            qslc_pkg::ST_SWAP_RD: begin
                elem_req.we    = 1'b1;
                elem_req.waddr = slot_reg;
                elem_req.wdata = hold_reg;
                hold_next      = elem_rdata;
            end
            qslc_pkg::ST_SWAP_WR: begin
                elem_req.we    = 1'b1;
                elem_req.waddr = j_reg;
                elem_req.wdata = hold_reg;
                xch_cnt_next   = qslc_pkg::sat_inc(xch_cnt_reg);
                slot_next      = slot_reg + IDX_W'(1);
                j_next         = j_inc;
            end
            // final pivot placement swaps slot and hi
            qslc_pkg::ST_PLACE: begin
                elem_req.re    = 1'b1;
                elem_req.raddr = slot_reg;
            end
            qslc_pkg::ST_PLACE_RD: begin
                elem_req.we    = 1'b1;
                elem_req.waddr = slot_reg;
                elem_req.wdata = pivot_reg;
                hold_next      = elem_rdata;
            end
            qslc_pkg::ST_PLACE_WR: begin
                elem_req.we    = 1'b1;
                elem_req.waddr = hi_reg;
                elem_req.wdata = hold_reg;
                xch_cnt_next   = qslc_pkg::sat_inc(xch_cnt_reg);
            end
            // right part pushed first so the left part is popped first
            qslc_pkg::ST_PUSH_HI: begin
                if (({1'b0, hi_reg} >= p_ext + CNT_W'(2)) && (sp_reg < STACK_CAP)) begin
                    stack_req.we    = 1'b1;
                    stack_req.waddr = sp_reg[IDX_W-1:0];
                    stack_req.wdata = {hi_reg, slot_reg + IDX_W'(1)};
                    sp_next         = sp_reg + CNT_W'(1);
                end
            end
            qslc_pkg::ST_PUSH_LO: begin
                if ((p_ext >= {1'b0, lo_reg} + CNT_W'(2)) && (sp_reg < STACK_CAP)) begin
                    stack_req.we    = 1'b1;
                    stack_req.waddr = sp_reg[IDX_W-1:0];
                    stack_req.wdata = {slot_reg - IDX_W'(1), lo_reg};
                    sp_next         = sp_reg + CNT_W'(1);
                end
            end
            // read next sorted element once the output register frees up
            qslc_pkg::ST_OUT_RD: begin
                if (out_free) begin
                    elem_req.re    = 1'b1;
                    elem_req.raddr = out_k_reg;
                end
            end
            qslc_pkg::ST_OUT_LD: begin
                out_valid_next = 1'b1;
                out_value_next = elem_rdata;
                out_last_next  = out_is_last;
                out_cmp_next   = cmp_cnt_reg;
                out_xch_next   = xch_cnt_reg;
                out_ovf_next   = dropped_reg;
                out_k_next     = out_k_reg + IDX_W'(1);
                if (out_is_last) begin
                    item_cnt_next = '0;
                    dropped_next  = 1'b0;
                    sp_next       = '0;
                    cmp_cnt_next  = '0;
                    xch_cnt_next  = '0;
                    out_k_next    = '0;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qslc_pkg::ST_LOAD;
            item_cnt_reg  <= '0;
            dropped_reg   <= 1'b0;
            sp_reg        <= '0;
            cmp_cnt_reg   <= '0;
            xch_cnt_reg   <= '0;
            out_k_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            item_cnt_reg  <= item_cnt_next;
            dropped_reg   <= dropped_next;
            sp_reg        <= sp_next;
            cmp_cnt_reg   <= cmp_cnt_next;
            xch_cnt_reg   <= xch_cnt_next;
            out_k_reg     <= out_k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        j_reg         <= j_next;
        slot_reg      <= slot_next;
        pivot_reg     <= pivot_next;
        hold_reg      <= hold_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_cmp_reg   <= out_cmp_next;
        out_xch_reg   <= out_xch_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_xch_reg, out_cmp_reg, out_value_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    // sequencer never reads and writes one element in the same cycle
    a_no_elem_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(elem_req.we && elem_req.re && (elem_req.waddr == elem_req.raddr)))
        else $error("element store read and write collide");

    // a full store drops the item and flags it
    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (item_cnt_reg == CAP)) |=> dropped_reg)
        else $error("dropped item not flagged");

    // output register is loaded only when free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qslc_pkg::ST_OUT_LD) |-> !out_valid_reg)
        else $error("output register overwritten");

    // fill level and stack depth stay in range
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_cnt_reg <= CAP) && (sp_reg <= STACK_CAP))
        else $error("item count or stack pointer out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/quicksort_lomuto_counting_top.sv @@
// quicksort_lomuto_counting_top: top level of the Lomuto quicksort block
// depends on qslc_pkg, qslc_elem_ram, qslc_stack_ram and qslc_ctrl
//
//  channel | dir | tdata (low bit up)                           | tlast       | tuser
//  s_      | in  | value[63:0]                                  | is_last     | -
//  m_      | out | sorted_value, comparison_count, exch_count   | end_of_run  | overflow
//
// load: one input transaction per cycle; the marked transaction starts the sort
// sort: each comparison scans then compares; each swap writes the slot element, then
//   the scanned one; each range is popped, its pivot fetched and placed, its parts pushed
// output: each result is read from memory, then loaded into the output register
// reset: control state only; memories are written before they are read
// stalls: s_tready is low outside loading; m_tready low holds the output register
`default_nettype none

module quicksort_lomuto_counting_top #(
    parameter int MAX_ITEMS = qslc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [qslc_pkg::VALUE_W-1:0]     s_tdata,   // value[63:0]
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // sorted_value[63:0], comparison_count[75:64], exchange_count[87:76]
    output logic [qslc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser    // overflow[0]
);

    qslc_pkg::elem_req_t             elem_req;
    qslc_pkg::stack_req_t            stack_req;
    logic [qslc_pkg::VALUE_W-1:0]    elem_rdata;
    logic [qslc_pkg::RANGE_W-1:0]    stack_rdata;

    // element store
    qslc_elem_ram u_elem_ram (
        .aclk    (aclk),
        .req     (elem_req),
        .rd_data (elem_rdata)
    );

    // pending range stack
    qslc_stack_ram u_stack_ram (
        .aclk    (aclk),
        .req     (stack_req),
        .rd_data (stack_rdata)
    );

    // sequencer and output register
    qslc_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .elem_req    (elem_req),
        .elem_rdata  (elem_rdata),
        .stack_req   (stack_req),
        .stack_rdata (stack_rdata)
    );

endmodule

`default_nettype wire
